/* design/sha1md_pkg.sv */
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants of the SHA-1 message digest block: item
// payloads, the controller to datapath command word and the round constants.
// ----------------------------------------------------------------------------
package sha1md_pkg;

    // payload of one input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } in_item_t;

    // payload of one result item
    typedef struct packed {
        logic [7:0] digest_byte;
        logic       digest_last;
    } out_item_t;

    // source of a byte pushed into the block window
    localparam logic [1:0] SRC_INPUT = 2'd0;
    localparam logic [1:0] SRC_PAD80 = 2'd1;
    localparam logic [1:0] SRC_ZERO  = 2'd2;
    localparam logic [1:0] SRC_LEN   = 2'd3;

    // round groups of the compression
    localparam logic [1:0] PH_CHOOSE   = 2'd0;
    localparam logic [1:0] PH_PARITY_A = 2'd1;
    localparam logic [1:0] PH_MAJORITY = 2'd2;
    localparam logic [1:0] PH_PARITY_B = 2'd3;

    localparam logic [7:0] PAD_MARK = 8'h80;

    // initial chaining value, h0 in the top word
    localparam logic [159:0] CHAIN_IV = {
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] K_CHOOSE   = 32'h5A827999;
    localparam logic [31:0] K_PARITY_A = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJORITY = 32'h8F1BBCDC;
    localparam logic [31:0] K_PARITY_B = 32'hCA62C1D6;

    // command word from the controller to the datapath
    typedef struct packed {
        logic       push;
        logic [1:0] push_sel;
        logic [2:0] len_idx;
        logic       count_byte;
        logic       load_vars;
        logic       round;
        logic [1:0] round_phase;
        logic       finalize;
        logic       out_shift;
        logic       clear;
    } dp_cmd_t;

    // round constant for a round group
    function automatic logic [31:0] round_k(input logic [1:0] phase);
        logic [31:0] k;
        case (phase)
            PH_CHOOSE:   k = K_CHOOSE;
            PH_PARITY_A: k = K_PARITY_A;
            PH_MAJORITY: k = K_MAJORITY;
            default:     k = K_PARITY_B;
        endcase
        return k;
    endfunction

endpackage

/* design/sha1md_stream_if.sv */
// ----------------------------------------------------------------------------
// sha1md_stream_if
// Valid/ready channel carrying one item payload of a given type.
// ----------------------------------------------------------------------------
interface sha1md_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

/* design/sha1md_datapath.sv */
// ----------------------------------------------------------------------------
// sha1md_datapath
// Block window (also the message schedule), round variables, chaining value
// and message length. Acts only on the command word from the controller.
// ----------------------------------------------------------------------------
module sha1md_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  sha1md_pkg::dp_cmd_t cmd,
    input  logic [7:0]         in_byte,
    output logic [7:0]         digest_byte
);
    import sha1md_pkg::*;

    logic [31:0]  win_reg  [16];
    logic [31:0]  win_next [16];
    logic [31:0]  vars_reg  [5];
    logic [31:0]  vars_next [5];
    logic [159:0] chain_reg;
    logic [159:0] chain_next;
    logic [60:0]  byte_count_reg;
    logic [60:0]  byte_count_next;

    logic [63:0]  len_bits;
    logic [7:0]   len_byte;
    logic [7:0]   push_byte;
    logic [31:0]  sched_new;
    logic [31:0]  f_val;
    logic [31:0]  temp_sum;

    // byte appended to the block
    assign len_bits = {byte_count_reg, 3'b000};
    assign len_byte = len_bits[{~cmd.len_idx, 3'b000} +: 8];

    always_comb
    begin
        case (cmd.push_sel)
            SRC_INPUT: push_byte = in_byte;
            SRC_PAD80: push_byte = PAD_MARK;
            SRC_ZERO:  push_byte = 8'h00;
            default:   push_byte = len_byte;
        endcase
    end

    // schedule word for sixteen rounds ahead
    assign sched_new = {win_reg[13][30:0] ^ win_reg[8][30:0] ^ win_reg[2][30:0]
                        ^ win_reg[0][30:0],
                        win_reg[13][31] ^ win_reg[8][31] ^ win_reg[2][31]
                        ^ win_reg[0][31]};

    // round function
    always_comb
    begin
        case (cmd.round_phase)
            PH_CHOOSE:   f_val = (vars_reg[1] & vars_reg[2]) | (~vars_reg[1] & vars_reg[3]);
            PH_MAJORITY: f_val = (vars_reg[1] & vars_reg[2]) | (vars_reg[1] & vars_reg[3])
                                 | (vars_reg[2] & vars_reg[3]);
            default:     f_val = vars_reg[1] ^ vars_reg[2] ^ vars_reg[3];
        endcase
    end

    assign temp_sum = {vars_reg[0][26:0], vars_reg[0][31:27]} + f_val + vars_reg[4]
                      + round_k(cmd.round_phase) + win_reg[0];

    // window: byte shift on push, word shift on a round
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (cmd.push)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = {win_reg[i][23:0], win_reg[i + 1][31:24]};
            end
            win_next[15] = {win_reg[15][23:0], push_byte};
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[15] = sched_new;
        end
    end

    // round variables
    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            vars_next[i] = vars_reg[i];
        end
        if (cmd.load_vars)
        begin
            for (int i = 0; i < 5; i++)
            begin
                vars_next[i] = chain_reg[159 - 32 * i -: 32];
            end
        end
        else if (cmd.round)
        begin
            vars_next[0] = temp_sum;
            vars_next[1] = vars_reg[0];
            vars_next[2] = {vars_reg[1][1:0], vars_reg[1][31:2]};
            vars_next[3] = vars_reg[2];
            vars_next[4] = vars_reg[3];
        end
    end

    // chaining value and message length
    always_comb
    begin
        chain_next      = chain_reg;
        byte_count_next = byte_count_reg;
        if (cmd.clear)
        begin
            chain_next      = CHAIN_IV;
            byte_count_next = '0;
        end
        else
        begin
            if (cmd.finalize)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    chain_next[159 - 32 * i -: 32] = chain_reg[159 - 32 * i -: 32]
                                                     + vars_reg[i];
                end
            end
            else if (cmd.out_shift)
            begin
                chain_next = {chain_reg[151:0], 8'h00};
            end
            if (cmd.count_byte)
            begin
                byte_count_next = byte_count_reg + 61'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        vars_reg <= vars_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg      <= CHAIN_IV;
            byte_count_reg <= '0;
        end
        else
        begin
            chain_reg      <= chain_next;
            byte_count_reg <= byte_count_next;
        end
    end

    assign digest_byte = chain_reg[159:152];

endmodule

/* design/sha1md_ctrl.sv */
// ----------------------------------------------------------------------------
// sha1md_ctrl
// Sequencer of the digest block: byte intake, padding, the 80 compression
// rounds and the 20-byte digest readout.
// ----------------------------------------------------------------------------
module sha1md_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_has_byte,
    input  logic                in_last,
    output logic                in_ready,
    output logic                out_valid,
    output logic                out_last,
    input  logic                out_ready,
    output sha1md_pkg::dp_cmd_t cmd
);
    import sha1md_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_FINAL = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [4:0] OUT_LAST   = 5'd19;

    logic [2:0] state_reg, state_next;
    logic [5:0] fill_reg, fill_next;
    logic [6:0] round_reg, round_next;
    logic [4:0] out_cnt_reg, out_cnt_next;
    logic       pad_active_reg, pad_active_next;
    logic       sent80_reg, sent80_next;
    logic       len_due_reg, len_due_next;
    logic       len_done_reg, len_done_next;

    logic       block_full;
    logic [1:0] phase;

    assign block_full = &fill_reg;

    // round group from the round number
    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            phase = PH_CHOOSE;
        end
        else if (round_reg < 7'd40)
        begin
            phase = PH_PARITY_A;
        end
        else if (round_reg < 7'd60)
        begin
            phase = PH_MAJORITY;
        end
        else
        begin
            phase = PH_PARITY_B;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_last  = (out_cnt_reg == OUT_LAST);

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        round_next      = round_reg;
        out_cnt_next    = out_cnt_reg;
        pad_active_next = pad_active_reg;
        sent80_next     = sent80_reg;
        len_due_next    = len_due_reg;
        len_done_next   = len_done_reg;

        cmd             = '0;
        cmd.push_sel    = SRC_INPUT;
        cmd.round_phase = phase;
        cmd.len_idx     = fill_reg[2:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_has_byte)
                    begin
                        cmd.push       = 1'b1;
                        cmd.count_byte = 1'b1;
                        fill_next      = fill_reg + 6'd1;
                    end
                    pad_active_next = in_last;
                    if (in_has_byte && block_full)
                    begin
                        cmd.load_vars = 1'b1;
                        round_next    = '0;
                        state_next    = S_ROUND;
                    end
                    else if (in_last)
                    begin
                        state_next = S_PAD;
                    end
                end
            end

            S_PAD:
            begin
                cmd.push  = 1'b1;
                fill_next = fill_reg + 6'd1;
                if (!sent80_reg)
                begin
                    cmd.push_sel = SRC_PAD80;
                    sent80_next  = 1'b1;
                    // length fits this block only if the mark lands before byte 56
                    len_due_next = (fill_reg[5:3] != 3'b111);
                end
                else if (fill_reg[5:3] != 3'b111 || !len_due_reg)
                begin
                    cmd.push_sel = SRC_ZERO;
                end
                else
                begin
                    cmd.push_sel  = SRC_LEN;
                    len_done_next = block_full;
                end
                if (block_full)
                begin
                    cmd.load_vars = 1'b1;
                    round_next    = '0;
                    len_due_next  = 1'b1;
                    state_next    = S_ROUND;
                end
            end

            S_ROUND:
            begin
                cmd.round  = 1'b1;
                round_next = round_reg + 7'd1;
                if (round_reg == ROUND_LAST)
                begin
                    state_next = S_FINAL;
                end
            end

            S_FINAL:
            begin
                cmd.finalize = 1'b1;
                if (len_done_reg)
                begin
                    out_cnt_next = '0;
                    state_next   = S_OUT;
                end
                else if (pad_active_reg)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_OUT:
            begin
                if (out_ready)
                begin
                    cmd.out_shift = 1'b1;
                    out_cnt_next  = out_cnt_reg + 5'd1;
                    if (out_cnt_reg == OUT_LAST)
                    begin
                        cmd.clear       = 1'b1;
                        fill_next       = '0;
                        pad_active_next = 1'b0;
                        sent80_next     = 1'b0;
                        len_due_next    = 1'b0;
                        len_done_next   = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            round_reg      <= '0;
            out_cnt_reg    <= '0;
            pad_active_reg <= 1'b0;
            sent80_reg     <= 1'b0;
            len_due_reg    <= 1'b0;
            len_done_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            round_reg      <= round_next;
            out_cnt_reg    <= out_cnt_next;
            pad_active_reg <= pad_active_next;
            sent80_reg     <= sent80_next;
            len_due_reg    <= len_due_next;
            len_done_reg   <= len_done_next;
        end
    end

endmodule

/* design/sha1_message_digest_top.sv */
// Each message byte is taken into the window; every full 64-byte block then
// runs 80 rounds on one shared round unit plus the chaining add.
// After the last item, padding pushes the pad bytes (9 to 72), each padded
// block runs the rounds too, then 20 digest items at 1 per cycle while taken.
// Input is held off from a full block until its digest work ends.
// Reset: chaining value to the initial words, counts cleared, ready for a byte.
// ----------------------------------------------------------------------------
// sha1_message_digest_top
// SHA-1 digest of a byte stream: controller and datapath joined by one
// command word, valid/ready channels on both sides.
// ----------------------------------------------------------------------------
module sha1_message_digest_top (
    input  logic                  clk,
    input  logic                  rst_n,
    sha1md_stream_if.sink         msg,
    sha1md_stream_if.source       dst
);
    import sha1md_pkg::*;

    dp_cmd_t    cmd;
    logic [7:0] digest_byte;
    logic       digest_last;

    // sequencer
    sha1md_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (msg.valid),
        .in_has_byte (msg.payload.has_byte),
        .in_last     (msg.payload.last),
        .in_ready    (msg.ready),
        .out_valid   (dst.valid),
        .out_last    (digest_last),
        .out_ready   (dst.ready),
        .cmd         (cmd)
    );

    // window, rounds and chaining value
    sha1md_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_byte     (msg.payload.data_byte),
        .digest_byte (digest_byte)
    );

    // result item payload
    assign dst.payload.digest_byte = digest_byte;
    assign dst.payload.digest_last = digest_last;

endmodule

/* design/sha1md_checker.sv */
// ----------------------------------------------------------------------------
// sha1md_checker
// Port-level checks of the digest block, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sha1md_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_last,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last
);

    // input is never taken while a digest is being shown
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while digest valid");

    // a message end stalls the input for padding
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_last) |=> !in_ready)
        else $error("input ready right after message end");

    // after the final digest item the block is back to taking input
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_last) |=> (in_ready && !out_valid))
        else $error("block not idle after final digest item");

    // a stalled digest item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(out_last)))
        else $error("digest item changed while stalled");

endmodule

bind sha1_message_digest_top sha1md_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (msg.valid),
    .in_ready  (msg.ready),
    .in_last   (msg.payload.last),
    .out_valid (dst.valid),
    .out_ready (dst.ready),
    .out_byte  (dst.payload.digest_byte),
    .out_last  (dst.payload.digest_last)
);

/* dv/sha1_message_digest_top_tb.sv */
// ----------------------------------------------------------------------------
// sha1_message_digest_top_tb
// Byte-stream SHA-1 digest checks: directed short messages, pad boundary
// lengths, random messages with idle items, and a long output hold-off.
// Every accepted byte updates a local SHA-1 model. Each digest byte that
// comes out is compared with the oldest predicted one.
// ----------------------------------------------------------------------------
module sha1_message_digest_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import sha1md_pkg::*;

    // items carrying a byte or last in the random part, on top of the pad boundary messages
    localparam int SHORT_MSG_ITEMS = 12;
    localparam int TAIL_CYCLES     = 100;

    logic clk = 1'b0;
    logic rst_n;

    sha1md_stream_if #(.payload_t(in_item_t))  msg_if ();
    sha1md_stream_if #(.payload_t(out_item_t)) dst_if ();

    sha1_message_digest_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_if),
        .dst   (dst_if)
    );

    always #1 clk = ~clk;

    // digest model state
    logic [31:0] chain_h [5];
    logic [7:0]  block_bytes [64];
    logic [5:0]  fill_n;
    logic [60:0] msg_len;

    out_item_t   digest_expect [$];
    int          mismatch_count  = 0;
    int          items_sent      = 0;

    // idle control shared by the sender and the receiver
    int          src_gap_max     = 0;
    int          sink_gap_max    = 0;
    int          hold_off_cycles = 0;
    bit          noise_on        = 1'b0;

    // ------------------------------------------------------------------
    // digest model
    // ------------------------------------------------------------------

    function automatic void digest_model_reset();
        chain_h[0] = CHAIN_IV[159:128];
        chain_h[1] = CHAIN_IV[127:96];
        chain_h[2] = CHAIN_IV[95:64];
        chain_h[3] = CHAIN_IV[63:32];
        chain_h[4] = CHAIN_IV[31:0];
        foreach (block_bytes[i])
            block_bytes[i] = 8'h00;
        fill_n  = '0;
        msg_len = '0;
    endfunction

    // 80 rounds over the full block, then the chaining add
    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        int          s;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1],
                    block_bytes[4*i+2], block_bytes[4*i+3]};
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++) begin
            s = r % 16;
            if (r >= 16) begin
                t    = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[s];
                w[s] = {t[30:0], t[31]};
            end
            if (r < 20) begin
                f = (b & c) | (~b & d);
                k = K_CHOOSE;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_PARITY_A;
            end else if (r < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_MAJORITY;
            end else begin
                f = b ^ c ^ d;
                k = K_PARITY_B;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[s];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    function automatic void push_block_byte(input logic [7:0] v);
        block_bytes[fill_n] = v;
        fill_n++;
        if (fill_n == 0)
            compress_block();
    endfunction

    // take one accepted item; a last item queues the 20 digest bytes
    function automatic void absorb_item(input logic [7:0] b, input logic hb,
                                        input logic lst);
        logic [63:0] bit_len;
        out_item_t   o;
        if (hb || lst)
            items_sent++;
        if (hb) begin
            push_block_byte(b);
            msg_len++;
        end
        if (!lst)
            return;
        bit_len = {msg_len, 3'b000};
        push_block_byte(PAD_MARK);
        while (fill_n != 6'd56)
            push_block_byte(8'h00);
        for (int i = 0; i < 8; i++)
            push_block_byte(bit_len[63 - 8*i -: 8]);
        for (int i = 0; i < 20; i++) begin
            o.digest_byte = chain_h[i / 4][31 - 8*(i % 4) -: 8];
            o.digest_last = (i == 19);
            digest_expect.push_back(o);
        end
        digest_model_reset();
    endfunction

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    task automatic send_item(input logic [7:0] b, input logic hb, input logic lst);
        int gap;
        gap = (src_gap_max > 0) ? $urandom_range(src_gap_max, 0) : 0;
        if (gap > 0) begin
            msg_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_if.valid   <= 1'b1;
        msg_if.payload <= '{data_byte: b, has_byte: hb, last: lst};
        do @(posedge clk); while (!msg_if.ready);
        absorb_item(b, hb, lst);
    endtask

    // stop offering and wait until every predicted digest byte is out
    task automatic drain_digests();
        msg_if.valid <= 1'b0;
        @(posedge clk);
        while (digest_expect.size() != 0)
            @(posedge clk);
    endtask

    // random bytes; last rides on the final byte or on an empty item
    task automatic send_random_message(input int len);
        bit end_on_byte;
        end_on_byte = $urandom_range(1, 0);
        for (int i = 0; i < len; i++) begin
            if (noise_on && $urandom_range(7, 0) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
        end
        if (len == 0 || !end_on_byte)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    // each side, on its own, runs without idling one time in four
    task automatic pick_idle_mode();
        src_gap_max  = ($urandom_range(3, 0) == 0) ? 0 : 9;
        sink_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 9;
    endtask

    // ------------------------------------------------------------------
    // receiver side and result check
    // ------------------------------------------------------------------

    initial begin : digest_sink
        int        stall;
        out_item_t got;
        out_item_t want;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_off_cycles > 0) begin
                stall           = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                stall = (sink_gap_max > 0) ? $urandom_range(sink_gap_max, 0) : 0;
            end
            if (stall > 0) begin
                dst_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            dst_if.ready <= 1'b1;
            do @(posedge clk); while (!dst_if.valid && hold_off_cycles == 0);
            if (dst_if.valid) begin
                got = dst_if.payload;
                if (digest_expect.size() == 0) begin
                    $error("unexpected digest item: digest_byte 0x%02h digest_last %0b",
                           got.digest_byte, got.digest_last);
                    mismatch_count++;
                end else begin
                    want = digest_expect.pop_front();
                    if (got.digest_byte !== want.digest_byte) begin
                        $error("digest_byte mismatch: expected 0x%02h, actual 0x%02h",
                               want.digest_byte, got.digest_byte);
                        mismatch_count++;
                    end
                    if (got.digest_last !== want.digest_last) begin
                        $error("digest_last mismatch: expected %0b, actual %0b",
                               want.digest_last, got.digest_last);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_directed_messages();
        src_gap_max  = 9;
        sink_gap_max = 9;
        noise_on     = 1'b0;
        // empty message straight after reset
        send_item(8'h00, 1'b0, 1'b1);
        // items with no byte and no last leave the state alone
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        // one-byte messages at both byte extremes, last on the byte
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        // "abc" with an idle item inside, closed by an empty last item
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b0);
        send_item(8'hAA, 1'b0, 1'b1);
        // last carried by a byte after earlier bytes
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h5A, 1'b1, 1'b1);
        // empty messages right after a digest, back to back
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
        drain_digests();
    endtask

    // lengths that need an extra pad block or fill a block with data
    task automatic test_block_boundaries();
        int pad_lens [2] = '{56, 64};
        noise_on = 1'b0;
        foreach (pad_lens[i]) begin
            pick_idle_mode();
            send_random_message(pad_lens[i]);
        end
        drain_digests();
    endtask

    task automatic test_random_messages();
        int start_items;
        int msg_n;
        int len;
        start_items = items_sent;
        msg_n       = 0;
        noise_on    = 1'b1;
        while (items_sent - start_items < SHORT_MSG_ITEMS) begin
            pick_idle_mode();
            len = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 13)
                                              : $urandom_range(12, 0);
            send_random_message(len);
            msg_n++;
            // sender pauses until every digest is out now and then
            if (msg_n % 4 == 0)
                drain_digests();
        end
        drain_digests();
    endtask

    // receiver holds off while the sender keeps offering, block backs up
    task automatic test_output_backpressure();
        src_gap_max     = 0;
        sink_gap_max    = 0;
        noise_on        = 1'b0;
        hold_off_cycles = 500;
        send_random_message(12);
        send_random_message(8);
        drain_digests();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        rst_n          = 1'b0;
        msg_if.valid   = 1'b0;
        msg_if.payload = '0;
        dst_if.ready   = 1'b0;
        digest_model_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_messages();
        test_block_boundaries();
        test_random_messages();
        test_output_backpressure();

        // catch any stray digest items
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // run limit
    initial begin : run_limit
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
